FILE: rtl/pair_sum_linear_probe_hash_assert.svh
// Assertion macros for the pair sum hash matcher checker.
// Plain text macros only; no dependencies.
`ifndef PAIR_SUM_LINEAR_PROBE_HASH_ASSERT_SVH
`define PAIR_SUM_LINEAR_PROBE_HASH_ASSERT_SVH

// Concurrent assertion, switched off while reset is high.
`define PSH_ASSERT_RST(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Concurrent assertion that also holds across reset.
`define PSH_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/psh_pkg.sv
// Shared types, widths, codes and helpers of the pair sum hash matcher.
// No dependencies.
package psh_pkg;

   localparam int TABLE_SIZE_DEF = 2048;
   localparam int QUEUE_DEPTH    = 4;

   localparam int COORD_W   = 16;
   localparam int IDX_W     = 5;
   localparam int TGT_W     = 18;
   localparam int KEY_W     = 19;  // lookup key at full width
   localparam int SKEY_W    = 18;  // stored key, holds any pair sum
   localparam int HV_W      = 22;  // 3*kx + ky
   localparam int U_W       = 23;  // offset hash value, never negative
   localparam int PROBE_W   = 12;
   localparam int PROBE_MAX = 4095;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_X = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_TARGET_Y = 4'd1;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic                      cmd;
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic [IDX_W-1:0]          first_index;
      logic [IDX_W-1:0]          second_index;
   } req_type;

   typedef struct packed {
      logic             found;
      logic             table_full;
      logic [IDX_W-1:0] match_first;
      logic [IDX_W-1:0] match_second;
   } rsp_type;

   typedef struct packed {
      logic signed [TGT_W-1:0] target_x;
      logic signed [TGT_W-1:0] target_y;
   } cfg_type;

   typedef struct packed {
      logic                    cmd;
      logic signed [KEY_W-1:0] key_x;
      logic signed [KEY_W-1:0] key_y;
      logic [IDX_W-1:0]        first_index;
      logic [IDX_W-1:0]        second_index;
   } job_type;

   typedef struct packed {
      logic signed [SKEY_W-1:0] key_x;
      logic signed [SKEY_W-1:0] key_y;
      logic [IDX_W-1:0]         first_index;
      logic [IDX_W-1:0]         second_index;
   } entry_type;

   localparam int JOB_W   = $bits(job_type);
   localparam int ENTRY_W = $bits(entry_type);

   function automatic logic signed [KEY_W-1:0] ext_coord(input logic [COORD_W-1:0] v);
      return {{(KEY_W-COORD_W){v[COORD_W-1]}}, v};
   endfunction

   function automatic logic signed [KEY_W-1:0] ext_target(input logic [TGT_W-1:0] v);
      return {{(KEY_W-TGT_W){v[TGT_W-1]}}, v};
   endfunction

   function automatic logic signed [HV_W-1:0] ext_key(input logic [KEY_W-1:0] v);
      return {{(HV_W-KEY_W){v[KEY_W-1]}}, v};
   endfunction

   function automatic logic signed [KEY_W-1:0] ext_stored(input logic [SKEY_W-1:0] v);
      return {{(KEY_W-SKEY_W){v[SKEY_W-1]}}, v};
   endfunction

endpackage

FILE: rtl/pair_sum_linear_probe_hash.sv
// Pair sum matcher on a linear probing hash table: top level.
// Depends on psh_pkg, psh_front, psh_queue, psh_back.
//
// Usage:
//   Input channel: push/full carry one item (req_data). cmd insert stores the
//   pair sum with both indices; cmd lookup searches for target minus the pair.
//   Result channel: empty/pop; every item gives exactly one result item, in order.
//   Configuration: csr_valid/csr_ready with csr_index and csr_data; target_x is
//   index 0, target_y index 1, the low 18 bits of csr_data are taken. csr_ready
//   is always high. Write only while no item is in flight.
// Flow:
//   The front forms the key and, for a power-of-two table, takes the low hash
//   bits; other sizes add remainder steps (estimate, subtract, correct). The back
//   issues the first RAM read, then probes one slot at a time (inserts probe up
//   to the first free slot or the whole table, lookups up to max_probe + 1 slots),
//   since the slot RAMs have a single read port. Front and back overlap through a
//   4 item queue.
// Reset and stalls:
//   After reset the valid store is cleared, one slot per cycle; full stays high
//   during that pass. A result waits in one output register; while it is not
//   popped the back holds its next item, but the front and queue keep
//   accepting items until the queue fills.
module pair_sum_linear_probe_hash
   import psh_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  req_type               req_data,
   output logic                  empty,
   input  logic                  pop,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int AW  = $clog2(TABLE_SIZE);
   localparam int Q_W = JOB_W + AW;

   cfg_type        cfg_ff, cfg_in;
   logic           clearing;
   logic           fq_push, fq_full;
   logic [Q_W-1:0] fq_wdata;
   logic           bq_pop, bq_empty;
   logic [Q_W-1:0] bq_rdata;

   // Configuration registers; the port never stalls.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_TARGET_X: cfg_in.target_x = csr_data[TGT_W-1:0];
            REG_TARGET_Y: cfg_in.target_y = csr_data[TGT_W-1:0];
            default: begin
               // Drop writes to unknown registers.
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept, form the key, reduce the hash. Hold off while clearing.
   psh_front #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .hold     (clearing),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .q_push   (fq_push),
      .q_full   (fq_full),
      .q_data   (fq_wdata)
   );

   // Decouple key formation from the probe engine.
   psh_queue #(
      .WIDTH (Q_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fq_push),
      .wr_data (fq_wdata),
      .full    (fq_full),
      .rd_en   (bq_pop),
      .rd_data (bq_rdata),
      .empty   (bq_empty)
   );

   // Back: probe the table one slot a cycle and present the result.
   psh_back #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (bq_empty),
      .q_pop    (bq_pop),
      .q_data   (bq_rdata),
      .clearing (clearing),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

FILE: rtl/psh_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module psh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/psh_queue.sv
// Short flop based queue between the front and back parts.
// Depends on psh_pkg for the default depth.
module psh_queue
   import psh_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             rd_en,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: rtl/psh_front.sv
// Front part: accepts items, forms the key and reduces the hash to a slot.
// Depends on psh_pkg.
module psh_front
   import psh_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   localparam int AW = $clog2(TABLE_SIZE)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                hold,
   input  logic                push,
   output logic                full,
   input  req_type             req_data,
   input  cfg_type             cfg,
   output logic                q_push,
   input  logic                q_full,
   output logic [JOB_W+AW-1:0] q_data
);

   localparam bit IS_POW2 = (TABLE_SIZE == (1 << AW));
   localparam int STEP_W  = 2;
   // Multiple of the table size that lifts every hash value above zero.
   localparam int OFFSET  = TABLE_SIZE * ((2**(HV_W-1) + TABLE_SIZE - 1) / TABLE_SIZE);
   // Table size reciprocal scaled by 2**U_W; the quotient it gives is exact
   // or one short for any offset hash value.
   localparam logic [U_W-1:0] RECIP  = U_W'((longint'(1) << U_W) / TABLE_SIZE);
   localparam logic [U_W-1:0] SIZE_U = U_W'(TABLE_SIZE);

   localparam logic [1:0] F_IDLE   = 2'd0;
   localparam logic [1:0] F_KEY    = 2'd1;
   localparam logic [1:0] F_REDUCE = 2'd2;
   localparam logic [1:0] F_PUSH   = 2'd3;

   logic [1:0]        state_ff, state_in;
   req_type           req_ff, req_in;
   job_type           job_ff, job_in;
   logic [U_W-1:0]    u_ff, u_in;
   logic [U_W-1:0]    quot_ff, quot_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [AW-1:0]     hash_ff, hash_in;

   logic                   accept;
   logic signed [KEY_W-1:0] key_x, key_y;
   logic signed [HV_W-1:0]  kx_h, ky_h, hval;
   logic [U_W-1:0]          u_start, u_next;
   logic [2*U_W-1:0]        prod, qt_prod;

   assign full   = (state_ff != F_IDLE) || hold;
   assign accept = push && !full;
   assign q_push = (state_ff == F_PUSH);
   assign q_data = {hash_ff, job_ff};

   always_comb begin
      if (req_ff.cmd == CMD_INSERT) begin
         key_x = ext_coord(req_ff.first_x) + ext_coord(req_ff.second_x);
         key_y = ext_coord(req_ff.first_y) + ext_coord(req_ff.second_y);
      end else begin
         key_x = ext_target(cfg.target_x) - ext_coord(req_ff.first_x)
               - ext_coord(req_ff.second_x);
         key_y = ext_target(cfg.target_y) - ext_coord(req_ff.first_y)
               - ext_coord(req_ff.second_y);
      end
      kx_h    = ext_key(key_x);
      ky_h    = ext_key(key_y);
      hval    = kx_h + (kx_h <<< 1) + ky_h;
      u_start = {{(U_W-HV_W){hval[HV_W-1]}}, hval} + U_W'(OFFSET);
      prod    = (2*U_W)'(u_ff) * (2*U_W)'(RECIP);
      qt_prod = (2*U_W)'(quot_ff) * (2*U_W)'(SIZE_U);
      u_next  = (u_ff >= SIZE_U) ? u_ff - SIZE_U : u_ff;
   end

   always_comb begin
      state_in = state_ff;
      req_in   = req_ff;
      job_in   = job_ff;
      u_in     = u_ff;
      quot_in  = quot_ff;
      step_in  = step_ff;
      hash_in  = hash_ff;
      case (state_ff)
         F_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               state_in = F_KEY;
            end
         end
         F_KEY: begin
            job_in.cmd          = req_ff.cmd;
            job_in.key_x        = key_x;
            job_in.key_y        = key_y;
            job_in.first_index  = req_ff.first_index;
            job_in.second_index = req_ff.second_index;
            if (IS_POW2) begin
               // Two's complement low bits are already the non-negative residue.
               hash_in  = hval[AW-1:0];
               state_in = F_PUSH;
            end else begin
               u_in     = u_start;
               step_in  = STEP_W'(2);
               state_in = F_REDUCE;
            end
         end
         F_REDUCE: begin
            // Estimate the quotient, take its multiple off, then correct once.
            if (step_ff == STEP_W'(2)) begin
               quot_in = prod[2*U_W-1:U_W];
            end else if (step_ff == STEP_W'(1)) begin
               u_in = u_ff - qt_prod[U_W-1:0];
            end else begin
               hash_in  = u_next[AW-1:0];
               state_in = F_PUSH;
            end
            step_in = step_ff - 1'b1;
         end
         F_PUSH: begin
            if (!q_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      job_ff  <= job_in;
      u_ff    <= u_in;
      quot_ff <= quot_in;
      step_ff <= step_in;
      hash_ff <= hash_in;
   end

endmodule

FILE: rtl/psh_back.sv
// Back part: clears the valid store, probes the table and holds the result.
// Depends on psh_pkg and psh_ram.
module psh_back
   import psh_pkg::*;
#(
   parameter int TABLE_SIZE = TABLE_SIZE_DEF,
   localparam int AW = $clog2(TABLE_SIZE)
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_empty,
   output logic                q_pop,
   input  logic [JOB_W+AW-1:0] q_data,
   output logic                clearing,
   output logic                empty,
   input  logic                pop,
   output rsp_type             rsp_data
);

   localparam int CW = (AW > PROBE_W) ? AW : PROBE_W;

   localparam logic [1:0] B_CLEAR = 2'd0;
   localparam logic [1:0] B_IDLE  = 2'd1;
   localparam logic [1:0] B_PROBE = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [AW-1:0]      cur_ff, cur_in;
   logic [AW-1:0]      dist_ff, dist_in;
   job_type            job_ff, job_in;
   logic [PROBE_W-1:0] max_probe_ff, max_probe_in;
   rsp_type            rsp_ff, rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   job_type            head_job;
   logic [AW-1:0]      head_hash;
   logic [AW-1:0]      next_idx;
   logic [AW-1:0]      rd_addr;
   logic [0:0]         valid_rd;
   logic [ENTRY_W-1:0] entry_raw;
   entry_type          entry_rd;
   logic               valid_we, entry_we;
   logic [AW-1:0]      valid_wa;
   logic [0:0]         valid_wd;
   entry_type          entry_wd;
   logic               start, last, key_hit, budget_end;
   logic [CW-1:0]      dist_cw;
   logic [PROBE_W-1:0] dist_sat;

   assign head_job  = job_type'(q_data[JOB_W-1:0]);
   assign head_hash = q_data[JOB_W +: AW];
   assign entry_rd  = entry_type'(entry_raw);

   assign clearing = (state_ff == B_CLEAR);
   assign empty    = !rsp_valid_ff;
   assign rsp_data = rsp_ff;

   assign start = (state_ff == B_IDLE) && !q_empty && !rsp_valid_ff;
   assign q_pop = start;

   assign next_idx = (cur_ff == AW'(TABLE_SIZE - 1)) ? '0 : cur_ff + 1'b1;
   assign rd_addr  = (state_ff == B_PROBE) ? next_idx : head_hash;

   assign last       = (dist_ff == AW'(TABLE_SIZE - 1));
   assign dist_cw    = CW'(dist_ff);
   assign budget_end = (dist_cw >= CW'(max_probe_ff)) || last;
   assign dist_sat   = (dist_cw > CW'(PROBE_MAX)) ? PROBE_W'(PROBE_MAX) : PROBE_W'(dist_cw);
   assign key_hit    = valid_rd[0]
                    && (ext_stored(entry_rd.key_x) == job_ff.key_x)
                    && (ext_stored(entry_rd.key_y) == job_ff.key_y);

   // Write ports of both stores.
   always_comb begin
      entry_wd.key_x        = job_ff.key_x[SKEY_W-1:0];
      entry_wd.key_y        = job_ff.key_y[SKEY_W-1:0];
      entry_wd.first_index  = job_ff.first_index;
      entry_wd.second_index = job_ff.second_index;
      entry_we = (state_ff == B_PROBE) && (job_ff.cmd == CMD_INSERT) && !valid_rd[0];
      if (state_ff == B_CLEAR) begin
         valid_we = 1'b1;
         valid_wa = clr_ff;
         valid_wd = 1'b0;
      end else begin
         valid_we = entry_we;
         valid_wa = cur_ff;
         valid_wd = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      cur_in       = cur_ff;
      dist_in      = dist_ff;
      job_in       = job_ff;
      max_probe_in = max_probe_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pop && rsp_valid_ff) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(TABLE_SIZE - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (start) begin
               job_in   = head_job;
               cur_in   = head_hash;
               dist_in  = '0;
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            rsp_in = '0;
            if (job_ff.cmd == CMD_INSERT) begin
               if (!valid_rd[0]) begin
                  if (dist_sat > max_probe_ff) begin
                     max_probe_in = dist_sat;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = B_IDLE;
               end else if (last) begin
                  rsp_in.table_full = 1'b1;
                  rsp_valid_in      = 1'b1;
                  state_in          = B_IDLE;
               end
            end else begin
               if (key_hit) begin
                  rsp_in.found        = 1'b1;
                  rsp_in.match_first  = entry_rd.first_index;
                  rsp_in.match_second = entry_rd.second_index;
                  rsp_valid_in        = 1'b1;
                  state_in            = B_IDLE;
               end else if (budget_end) begin
                  rsp_valid_in = 1'b1;
                  state_in     = B_IDLE;
               end
            end
            if (state_in == B_PROBE) begin
               cur_in  = next_idx;
               dist_in = dist_ff + 1'b1;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         max_probe_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         max_probe_ff <= max_probe_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff  <= cur_in;
      dist_ff <= dist_in;
      job_ff  <= job_in;
      rsp_ff  <= rsp_in;
   end

   psh_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SIZE)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (valid_wa),
      .wr_data (valid_wd),
      .rd_addr (rd_addr),
      .rd_data (valid_rd)
   );

   psh_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SIZE)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (entry_we),
      .wr_addr (cur_ff),
      .wr_data (entry_wd),
      .rd_addr (rd_addr),
      .rd_data (entry_raw)
   );

endmodule

FILE: rtl/psh_checker.sv
// Port level checker for the pair sum hash matcher, bound to the top level.
// Depends on psh_pkg and pair_sum_linear_probe_hash_assert.svh.
`include "pair_sum_linear_probe_hash_assert.svh"

module psh_checker
   import psh_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // Reset starts the clearing pass and drops any waiting result.
   `PSH_ASSERT_ALWAYS(a_reset_blocks, clock, reset |=> full && empty, "reset: not blocked")

   // One output register: a taken result leaves it empty.
   `PSH_ASSERT_RST(a_pop_drains, clock, reset, !empty && pop |=> empty, "result repeated")

   // A stalled result holds.
   `PSH_ASSERT_RST(a_stall_holds, clock, reset, !empty && !pop |=> !empty && $stable(rsp_data), "result moved while stalled")

   // No index comes back without a match, and found and full never meet.
   `PSH_ASSERT_RST(a_result_shape, clock, reset, !empty |-> !(rsp_data.found && rsp_data.table_full) && (rsp_data.found || (rsp_data.match_first == 5'd0 && rsp_data.match_second == 5'd0)), "malformed result")

endmodule

bind pair_sum_linear_probe_hash psh_checker u_checker (.*);
